// ===== rtl/core/adjacency_matrix_graph_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix graph engine
// Concurrent checks clocked on clk and disabled while rst is high. They
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_ENGINE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define AMGE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define AMGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AMGE_ASSERT(lbl, ante, cons, msg)
`define AMGE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/amge_pkg.sv =====
// ----------------------------------------------------------------------------
// Graph engine package
// Request and result types, operation codes and default sizes shared by the
// controller and the top level.
// ----------------------------------------------------------------------------
package amge_pkg;

  // Field widths fixed by the request and result formats.
  localparam int NODE_FIELD_BITS   = 6;
  localparam int WEIGHT_FIELD_BITS = 8;
  localparam int MASK_BITS         = 64;
  localparam int COUNT_BITS        = 12;
  localparam int CFG_BITS          = 7;

  // Defaults for the top-level parameters.
  localparam int DEF_NODES       = 64;
  localparam int DEF_WEIGHT_BITS = 8;

  // Reset value of the active node count register.
  localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  // Operation codes carried in request.operation.
  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_DELETE     = 3'd1,
    OP_SET_WEIGHT = 3'd2,
    OP_READ       = 3'd3,
    OP_COUNT      = 3'd4,
    OP_CONNECT    = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]                   operation;
    logic [NODE_FIELD_BITS-1:0]   node_a;
    logic [NODE_FIELD_BITS-1:0]   node_b;
    logic [WEIGHT_FIELD_BITS-1:0] weight;
  } req_t;

  typedef struct packed {
    logic                         edge_present;
    logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
    logic [MASK_BITS-1:0]         neighbour_mask;
    logic [COUNT_BITS-1:0]        edge_count;
    logic                         connected;
    logic                         index_error;
  } res_t;

endpackage

// ===== rtl/core/amge_row_mem.sv =====
// ----------------------------------------------------------------------------
// Adjacency row memory
// One row of NODES bits per node, one read and one write port, registered
// read data. Per-row valid bits make unwritten rows read as zero after reset,
// and a read of the row being written returns the new data.
// ----------------------------------------------------------------------------
module amge_row_mem #(
  parameter int NODES = amge_pkg::DEF_NODES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(NODES)-1:0] rd_addr,
  output logic [NODES-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(NODES)-1:0] wr_addr,
  input  logic [NODES-1:0]         wr_data
);
  import amge_pkg::*;

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] valid;

  // Row storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits are cleared by reset and set by the first write of a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read with write forwarding.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/amge_wgt_mem.sv =====
// ----------------------------------------------------------------------------
// Edge weight memory
// One weight per ordered node pair, addressed by {row, column}. Single write
// port, single read port with registered data. Contents are not cleared: a
// weight is only used while its edge bit is set.
// ----------------------------------------------------------------------------
module amge_wgt_mem #(
  parameter int NODES       = amge_pkg::DEF_NODES,
  parameter int WEIGHT_BITS = amge_pkg::DEF_WEIGHT_BITS
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [2*$clog2(NODES)-1:0] rd_addr,
  output logic [WEIGHT_BITS-1:0]     rd_data,
  input  logic                       wr_en,
  input  logic [2*$clog2(NODES)-1:0] wr_addr,
  input  logic [WEIGHT_BITS-1:0]     wr_data
);
  import amge_pkg::*;

  localparam int DEPTH = 1 << (2 * $clog2(NODES));

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/amge_ctrl.sv =====
// ----------------------------------------------------------------------------
// Graph engine controller
// Accepts requests, sequences read-modify-write of the row and weight
// memories, scans rows for edge counting and connectivity passes, and
// holds the node count register and the result register.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_graph_engine_assert.svh"

module amge_ctrl #(
  parameter int NODES       = amge_pkg::DEF_NODES,
  parameter int WEIGHT_BITS = amge_pkg::DEF_WEIGHT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  amge_pkg::req_t               request,
  output logic                         busy,
  output logic                         done,
  output amge_pkg::res_t               result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [amge_pkg::CFG_BITS-1:0] cfg_data,
  output logic                         row_re,
  output logic [$clog2(NODES)-1:0]     row_raddr,
  input  logic [NODES-1:0]             row_rdata,
  output logic                         row_we,
  output logic [$clog2(NODES)-1:0]     row_waddr,
  output logic [NODES-1:0]             row_wdata,
  output logic                         wgt_re,
  output logic [2*$clog2(NODES)-1:0]   wgt_raddr,
  input  logic [WEIGHT_BITS-1:0]       wgt_rdata,
  output logic                         wgt_we,
  output logic [2*$clog2(NODES)-1:0]   wgt_waddr,
  output logic [WEIGHT_BITS-1:0]       wgt_wdata
);
  import amge_pkg::*;

  localparam int NB = $clog2(NODES);
  localparam logic [NODES-1:0] ROW_ONE = NODES'(1);
  localparam logic [CFG_BITS-1:0] NODES_CFG = CFG_BITS'(NODES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROW_A = 5'b00010,
    ST_ROW_B = 5'b00100,
    ST_WGT_B = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  state_t                 state;
  logic [CFG_BITS-1:0]    node_count;
  logic [2:0]             op_q;
  logic [NODE_FIELD_BITS-1:0] a_q;
  logic [NODE_FIELD_BITS-1:0] b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [CFG_BITS-1:0]    n_q;
  logic [MASK_BITS-1:0]   act_q;
  res_t                   res;

  // Scan pipeline: issue index, returned row index, popcount lanes.
  logic [CFG_BITS-1:0]    scan_idx;
  logic                   rd_vld;
  logic [NODE_FIELD_BITS-1:0] rd_idx;
  logic                   pc_vld;
  logic                   pc_last;
  logic [7:0][3:0]        pc_lane;
  logic [COUNT_BITS-1:0]  total;

  // Connectivity sets and the visited set at the start of the pass.
  logic [MASK_BITS-1:0]   reached;
  logic [MASK_BITS-1:0]   visited;
  logic [MASK_BITS-1:0]   visited_start;

  logic                   accept;
  logic                   req_err;
  logic [CFG_BITS-1:0]    n_now;
  logic [MASK_BITS-1:0]   act_now;
  logic                   scan_issue;
  logic                   pass_end;
  logic [MASK_BITS-1:0]   row64;
  logic [MASK_BITS-1:0]   cnt_masked;
  logic [MASK_BITS-1:0]   vis_upd;
  logic [MASK_BITS-1:0]   rch_upd;
  logic                   hit;
  logic [6:0]             lane_sum;
  logic [COUNT_BITS-1:0]  total_sum;
  logic [NODES-1:0]       bit_a_row;
  logic [NODES-1:0]       bit_b_row;
  logic [WEIGHT_BITS-1:0] w_edit;
  logic                   edge_hit;
  res_t                   res_err;
  res_t                   res_rd;
  logic                   finish;
  res_t                   res_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && !busy;
  assign result    = res;

  // Active node count with out-of-range register values clamped.
  always_comb begin
    if (node_count == '0) begin
      n_now = CFG_BITS'(1);
    end else if (node_count > NODES_CFG) begin
      n_now = NODES_CFG;
    end else begin
      n_now = node_count;
    end
    if (n_now >= CFG_BITS'(MASK_BITS)) begin
      act_now = '1;
    end else begin
      act_now = (MASK_BITS'(1) << n_now) - MASK_BITS'(1);
    end
  end

  // Bad node index on an edge operation.
  assign req_err = (request.operation <= OP_READ) &&
                   (({1'b0, request.node_a} >= n_now) ||
                    ({1'b0, request.node_b} >= n_now));

  // Edge edit helpers.
  assign row64     = MASK_BITS'(row_rdata);
  assign bit_a_row = ROW_ONE << a_q[NB-1:0];
  assign bit_b_row = ROW_ONE << b_q[NB-1:0];
  assign edge_hit  = row_rdata[b_q[NB-1:0]];
  assign w_edit    = ((op_q == OP_ADD) && (a_q != b_q)) ? w_q : '0;

  // Scan control.
  assign scan_issue = (state == ST_SCAN) && (scan_idx < n_q);
  assign pass_end   = rd_vld && ({1'b0, rd_idx} == (n_q - CFG_BITS'(1)));

  // Edge count: mask the returned row to the upper triangle of active nodes.
  assign cnt_masked = row64 & act_q & ({MASK_BITS{1'b1}} << rd_idx);

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < 8; k++) begin
      lane_sum = lane_sum + 7'(pc_lane[k]);
    end
    total_sum = total + COUNT_BITS'(lane_sum);
  end

  // Connectivity: visit the returned row if it is reached and not yet visited.
  always_comb begin
    hit     = reached[rd_idx] && !visited[rd_idx];
    vis_upd = visited;
    rch_upd = reached;
    if (hit) begin
      vis_upd = visited | (MASK_BITS'(1) << rd_idx);
      rch_upd = reached | (row64 & act_q);
    end
  end

  // Result words for the error and read cases.
  always_comb begin
    res_err             = '0;
    res_err.index_error = 1'b1;
    res_rd                = '0;
    res_rd.edge_present   = edge_hit;
    res_rd.edge_weight    = edge_hit ? WEIGHT_FIELD_BITS'(wgt_rdata) : '0;
    res_rd.neighbour_mask = row64 & act_q;
  end

  // Request completion and the result word it leaves behind.
  always_comb begin
    finish   = 1'b0;
    res_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_err) begin
            finish   = 1'b1;
            res_next = res_err;
          end else if (!(request.operation inside {OP_ADD, OP_DELETE, OP_SET_WEIGHT,
                                                   OP_READ, OP_COUNT, OP_CONNECT})) begin
            finish = 1'b1;
          end
        end
      end
      ST_ROW_A: begin
        if (op_q == OP_READ) begin
          finish   = 1'b1;
          res_next = res_rd;
        end else if ((op_q == OP_SET_WEIGHT) && !edge_hit) begin
          finish = 1'b1;
        end
      end
      ST_ROW_B, ST_WGT_B: begin
        finish = 1'b1;
      end
      ST_SCAN: begin
        if (op_q == OP_COUNT) begin
          if (pc_vld && pc_last) begin
            finish              = 1'b1;
            res_next.edge_count = total_sum;
          end
        end else if (pass_end) begin
          if (vis_upd == act_q) begin
            finish             = 1'b1;
            res_next.connected = 1'b1;
          end else if (vis_upd == visited_start) begin
            finish = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Memory port drive.
  always_comb begin
    row_re    = 1'b0;
    row_raddr = scan_idx[NB-1:0];
    row_we    = 1'b0;
    row_waddr = a_q[NB-1:0];
    row_wdata = row_rdata;
    wgt_re    = 1'b0;
    wgt_raddr = {request.node_a[NB-1:0], request.node_b[NB-1:0]};
    wgt_we    = 1'b0;
    wgt_waddr = {a_q[NB-1:0], b_q[NB-1:0]};
    wgt_wdata = w_edit;
    case (state)
      ST_IDLE: begin
        if (accept && !req_err &&
            (request.operation inside {OP_ADD, OP_DELETE, OP_SET_WEIGHT, OP_READ})) begin
          row_re    = 1'b1;
          row_raddr = request.node_a[NB-1:0];
          wgt_re    = (request.operation == OP_READ);
        end
      end
      ST_ROW_A: begin
        if (op_q inside {OP_ADD, OP_DELETE}) begin
          row_we    = 1'b1;
          row_wdata = (op_q == OP_ADD) ? (row_rdata | bit_b_row) :
                                         (row_rdata & ~bit_b_row);
          row_re    = 1'b1;
          row_raddr = b_q[NB-1:0];
          wgt_we    = 1'b1;
        end else if ((op_q == OP_SET_WEIGHT) && edge_hit) begin
          wgt_we    = 1'b1;
          wgt_wdata = w_q;
        end
      end
      ST_ROW_B: begin
        row_we    = 1'b1;
        row_waddr = b_q[NB-1:0];
        row_wdata = (op_q == OP_ADD) ? (row_rdata | bit_a_row) :
                                       (row_rdata & ~bit_a_row);
        wgt_we    = 1'b1;
        wgt_waddr = {b_q[NB-1:0], a_q[NB-1:0]};
      end
      ST_WGT_B: begin
        wgt_we    = 1'b1;
        wgt_waddr = {b_q[NB-1:0], a_q[NB-1:0]};
        wgt_wdata = w_q;
      end
      ST_SCAN: begin
        row_re = scan_issue;
      end
      default: begin
      end
    endcase
  end

  // Scan pipeline payload.
  always_ff @(posedge clk) begin
    rd_idx  <= scan_idx[NODE_FIELD_BITS-1:0];
    pc_last <= pass_end;
    for (int k = 0; k < 8; k++) begin
      pc_lane[k] <= pop8(cnt_masked[8*k +: 8]);
    end
  end

  // Result register; loaded when a request finishes.
  always_ff @(posedge clk) begin
    if (finish) begin
      res <= res_next;
    end
  end

  // Sequencer and register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      node_count <= NODE_COUNT_RESET;
      rd_vld     <= 1'b0;
      pc_vld     <= 1'b0;
      reached    <= '0;
      visited    <= '0;
    end else begin
      done   <= finish;
      rd_vld <= scan_issue;
      pc_vld <= rd_vld && (op_q == OP_COUNT);
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q          <= request.operation;
            a_q           <= request.node_a;
            b_q           <= request.node_b;
            w_q           <= WEIGHT_BITS'(request.weight);
            n_q           <= n_now;
            act_q         <= act_now;
            scan_idx      <= '0;
            total         <= '0;
            visited_start <= '0;
            if (!req_err) begin
              if (request.operation inside {OP_ADD, OP_DELETE, OP_SET_WEIGHT,
                                            OP_READ}) begin
                state <= ST_ROW_A;
              end else if (request.operation == OP_COUNT) begin
                state <= ST_SCAN;
              end else if (request.operation == OP_CONNECT) begin
                state   <= ST_SCAN;
                reached <= MASK_BITS'(1);
                visited <= '0;
              end
            end
          end
        end
        ST_ROW_A: begin
          case (op_q)
            OP_ADD, OP_DELETE: begin
              state <= ST_ROW_B;
            end
            OP_SET_WEIGHT: begin
              state <= edge_hit ? ST_WGT_B : ST_IDLE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_ROW_B, ST_WGT_B: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_idx <= scan_idx + CFG_BITS'(1);
          end
          if (op_q == OP_COUNT) begin
            if (pc_vld) begin
              total <= total_sum;
              if (pc_last) begin
                state <= ST_IDLE;
              end
            end
          end else if (rd_vld) begin
            visited <= vis_upd;
            reached <= rch_upd;
            if (pass_end) begin
              if ((vis_upd == act_q) || (vis_upd == visited_start)) begin
                state <= ST_IDLE;
              end else begin
                visited_start <= vis_upd;
                scan_idx      <= '0;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `AMGE_ASSERT(a_release_with_result, $fell(busy), done, "busy fell without a result")
  `AMGE_ASSERT(a_row_we_state, row_we, (state == ST_ROW_A) || (state == ST_ROW_B), "stray row write")
  `AMGE_ASSERT(a_visited_in_reached, 1'b1, (visited & ~reached) == '0, "visited node not reached")
  `AMGE_ASSERT_NEXT(a_error_result, accept && req_err, done && result.index_error, "no error result")

endmodule

// ===== rtl/core/adjacency_matrix_graph_engine.sv =====
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine
// Undirected graph store with per-edge weights, edge counting and a
// connectivity check from node 0.
// ----------------------------------------------------------------------------
// Usage: a request is taken on a rising edge with start high and busy low.
// Each request gives one result on result, valid for the single cycle that
// done is high; the receiver cannot stall it. cfg_valid/cfg_ready writes the
// active node count; cfg_ready is high while no request is in progress.
// Work per request, with n active nodes: bad index or unused code: none;
//   read edge: row a and weight (a, b) read; set weight: row a read, both
//   weights written if the edge exists; add or delete: rows a and b and both
//   weights updated; count edges: one scan of the n rows; connectivity:
//   passes over the rows, at most n.
// The single row read port feeds a scan one row per cycle while the pass
// has rows left, and each read-modify-write. One request runs at a time.
// Reset: row valid bits clear in one cycle, so the graph is empty right after
// rst. The weight memory is not swept, as a weight is only shown while its
// edge exists. The node count returns to 64.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_engine #(
  parameter int NODES       = amge_pkg::DEF_NODES,
  parameter int WEIGHT_BITS = amge_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  amge_pkg::req_t                request,
  output logic                          busy,
  output logic                          done,
  output amge_pkg::res_t                result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amge_pkg::CFG_BITS-1:0] cfg_data
);
  import amge_pkg::*;

  localparam int NB = $clog2(NODES);

  logic                   row_re;
  logic [NB-1:0]          row_raddr;
  logic [NODES-1:0]       row_rdata;
  logic                   row_we;
  logic [NB-1:0]          row_waddr;
  logic [NODES-1:0]       row_wdata;
  logic                   wgt_re;
  logic [2*NB-1:0]        wgt_raddr;
  logic [WEIGHT_BITS-1:0] wgt_rdata;
  logic                   wgt_we;
  logic [2*NB-1:0]        wgt_waddr;
  logic [WEIGHT_BITS-1:0] wgt_wdata;

  // Request sequencer.
  amge_ctrl #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .row_re    (row_re),
    .row_raddr (row_raddr),
    .row_rdata (row_rdata),
    .row_we    (row_we),
    .row_waddr (row_waddr),
    .row_wdata (row_wdata),
    .wgt_re    (wgt_re),
    .wgt_raddr (wgt_raddr),
    .wgt_rdata (wgt_rdata),
    .wgt_we    (wgt_we),
    .wgt_waddr (wgt_waddr),
    .wgt_wdata (wgt_wdata)
  );

  // Adjacency rows.
  amge_row_mem #(
    .NODES (NODES)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (row_re),
    .rd_addr (row_raddr),
    .rd_data (row_rdata),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata)
  );

  // Edge weights.
  amge_wgt_mem #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wgt_mem (
    .clk     (clk),
    .rd_en   (wgt_re),
    .rd_addr (wgt_raddr),
    .rd_data (wgt_rdata),
    .wr_en   (wgt_we),
    .wr_addr (wgt_waddr),
    .wr_data (wgt_wdata)
  );

endmodule

// ===== tb/adjacency_matrix_graph_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph engine testbench
// Sends add, delete, re-weight, read, count and connectivity requests to the
// engine. Several active node counts are used in turn. Each result is checked
// field by field against an in-bench model of the adjacency matrix and the
// edge weights.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_engine_test;
  import amge_pkg::*;

  localparam int GRAPH_NODES = DEF_NODES;
  localparam int REPORT_LIMIT = 10;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_REQUESTS = 127;

  // Codes that the engine must ignore.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum logic [1:0] {
    ACT_REQUEST,
    ACT_CONFIG,
    ACT_DRAIN
  } action_kind_e;

  typedef struct packed {
    action_kind_e          kind;
    req_t                  req;
    logic [CFG_BITS-1:0]   value;
  } pending_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  req_t                req = '0;
  logic                busy;
  logic                done;
  res_t                res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // Model of the engine's state.
  logic [GRAPH_NODES-1:0] graph_rows [GRAPH_NODES];
  logic [7:0]             graph_weights [GRAPH_NODES][GRAPH_NODES];
  logic [CFG_BITS-1:0]    node_count_reg;

  pending_t pending_actions [$];
  res_t     expected_results [$];

  // Planning state used while the request list is built.
  int unsigned plan_nodes;
  int unsigned planned_requests = 0;
  int unsigned last_a = 0;
  int unsigned last_b = 0;
  longint unsigned cycle_budget = 0;

  int unsigned accepted_total = 0;
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;
  longint unsigned run_limit = 64'd5_000_000;

  int unsigned phase_nodes [12] = '{8, 1, 0, 64, 127, 5, 33, 16, 2, 63, 64, 12};

  adjacency_matrix_graph_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (req),
    .busy      (busy),
    .done      (done),
    .result    (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count 0 behaves as one node and anything above the matrix size as all.
  function automatic int unsigned effective_nodes(int unsigned value);
    if (value == 0) return 1;
    if (value > GRAPH_NODES) return GRAPH_NODES;
    return value;
  endfunction

  function automatic logic [GRAPH_NODES-1:0] active_mask(int unsigned n);
    if (n >= GRAPH_NODES) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic res_t apply_request(req_t rq);
    res_t                   r;
    int unsigned            n;
    int unsigned            a;
    int unsigned            b;
    int unsigned            total;
    logic [7:0]             w;
    logic [GRAPH_NODES-1:0] act;
    logic [GRAPH_NODES-1:0] reach;
    logic [GRAPH_NODES-1:0] seen;
    logic [GRAPH_NODES-1:0] prior;
    r = '0;
    n = effective_nodes(32'(node_count_reg));
    act = active_mask(n);
    a = 32'(rq.node_a);
    b = 32'(rq.node_b);
    w = rq.weight;
    total = 0;
    // Edge requests with a node outside the active range change nothing.
    if (rq.operation <= OP_READ && (a >= n || b >= n)) begin
      r.index_error = 1'b1;
      return r;
    end
    case (rq.operation)
      OP_ADD: begin
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
        if (a == b) w = '0;
        graph_weights[a][b] = w;
        graph_weights[b][a] = w;
      end
      OP_DELETE: begin
        graph_rows[a][b] = 1'b0;
        graph_rows[b][a] = 1'b0;
        graph_weights[a][b] = '0;
        graph_weights[b][a] = '0;
      end
      OP_SET_WEIGHT: begin
        if (graph_rows[a][b]) begin
          graph_weights[a][b] = w;
          graph_weights[b][a] = w;
        end
      end
      OP_READ: begin
        r.edge_present = graph_rows[a][b];
        r.edge_weight = graph_weights[a][b];
        r.neighbour_mask = graph_rows[a] & act;
      end
      OP_COUNT: begin
        // Upper triangle of the active rows, diagonal included.
        for (int i = 0; i < n; i++)
          total += $countones(graph_rows[i] & act & ~((64'd1 << i) - 64'd1));
        r.edge_count = total[COUNT_BITS-1:0];
      end
      OP_CONNECT: begin
        // Passes over the rows until every active node is visited or a pass
        // finds nothing new.
        reach = 64'd1;
        seen = '0;
        r.connected = 1'b1;
        while (seen != act) begin
          prior = seen;
          for (int i = 0; i < n; i++) begin
            if (reach[i] && !seen[i]) begin
              seen[i] = 1'b1;
              reach = reach | (graph_rows[i] & act);
            end
          end
          if (seen == prior) begin
            r.connected = 1'b0;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_request(logic [2:0] op, int unsigned a, int unsigned b,
                               int unsigned w);
    pending_t p;
    int unsigned n;
    n = plan_nodes;
    p.kind = ACT_REQUEST;
    p.value = '0;
    p.req.operation = op;
    p.req.node_a = a[NODE_FIELD_BITS-1:0];
    p.req.node_b = b[NODE_FIELD_BITS-1:0];
    p.req.weight = w[WEIGHT_FIELD_BITS-1:0];
    pending_actions.push_back(p);
    planned_requests++;
    // Worst case engine time plus a generous allowance for sender gaps.
    case (op)
      OP_CONNECT: cycle_budget += n * (n + 1) + 1;
      OP_COUNT:   cycle_budget += n + 3;
      default:    cycle_budget += 3;
    endcase
    cycle_budget += 40;
  endtask

  task automatic queue_config(int unsigned value);
    pending_t p;
    p = '0;
    p.kind = ACT_CONFIG;
    p.value = value[CFG_BITS-1:0];
    pending_actions.push_back(p);
    plan_nodes = effective_nodes(32'(value[CFG_BITS-1:0]));
    cycle_budget += 50;
  endtask

  task automatic queue_drain();
    pending_t p;
    p = '0;
    p.kind = ACT_DRAIN;
    pending_actions.push_back(p);
    cycle_budget += 50;
  endtask

  // One random request, biased toward edges that were recently added.
  task automatic queue_random_request();
    int unsigned pick;
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned w;
    logic [2:0]  op;
    n = plan_nodes;
    pick = $urandom_range(99);
    w = $urandom_range(255);
    a = $urandom_range(n - 1);
    b = $urandom_range(n - 1);
    if (pick < 28) op = OP_ADD;
    else if (pick < 40) op = OP_DELETE;
    else if (pick < 50) op = OP_SET_WEIGHT;
    else if (pick < 72) op = OP_READ;
    else if (pick < 82) op = OP_COUNT;
    else if (pick < 92) op = OP_CONNECT;
    else if (pick < 96) op = pick[0] ? OP_SPARE_B : OP_SPARE_A;
    else op = 3'($urandom_range(3));
    if ((op == OP_DELETE || op == OP_SET_WEIGHT || op == OP_READ) && $urandom_range(1)) begin
      a = last_a;
      b = last_b;
    end
    // Now and then any node index at all, and deliberate bad indexes.
    if ($urandom_range(24) == 0) begin
      a = $urandom_range(63);
      b = $urandom_range(63);
    end
    if (pick >= 96 && n < GRAPH_NODES) begin
      if ($urandom_range(1)) a = $urandom_range(63, n);
      else b = $urandom_range(63, n);
    end
    if (op == OP_ADD) begin
      last_a = a;
      last_b = b;
    end
    queue_request(op, a, b, w);
  endtask

  // Builds a spanning path or tree over the active nodes in random order,
  // checks connectivity, then may cut one edge and check again.
  task automatic queue_spanning();
    int unsigned n;
    int unsigned j;
    int unsigned tmp;
    int unsigned cut;
    int unsigned order [GRAPH_NODES];
    int unsigned partner [GRAPH_NODES];
    bit          as_path;
    n = plan_nodes;
    as_path = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 1; i--) begin
      j = $urandom_range(i, 1);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 1; i < n; i++) begin
      partner[i] = as_path ? order[i-1] : order[$urandom_range(i - 1)];
      queue_request(OP_ADD, order[i], partner[i], $urandom_range(255));
    end
    queue_request(OP_CONNECT, $urandom_range(63), $urandom_range(63), $urandom_range(255));
    if ($urandom_range(1)) begin
      cut = $urandom_range(n - 1, 1);
      queue_request(OP_DELETE, order[cut], partner[cut], 0);
      queue_request(OP_CONNECT, 0, 0, 0);
      queue_request(OP_READ, partner[cut], order[cut], 0);
    end
  endtask

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic check_result(res_t want, res_t got);
    if (got.edge_present !== want.edge_present)
      note_mismatch("edge_present", want.edge_present, got.edge_present);
    if (got.edge_weight !== want.edge_weight)
      note_mismatch("edge_weight", want.edge_weight, got.edge_weight);
    if (got.neighbour_mask !== want.neighbour_mask)
      note_mismatch("neighbour_mask", want.neighbour_mask, got.neighbour_mask);
    if (got.edge_count !== want.edge_count)
      note_mismatch("edge_count", want.edge_count, got.edge_count);
    if (got.connected !== want.connected)
      note_mismatch("connected", want.connected, got.connected);
    if (got.index_error !== want.index_error)
      note_mismatch("index_error", want.index_error, got.index_error);
  endtask

  // Driver: presents pending requests and register writes. A register write
  // or a drain waits until every expected result has come back.
  always @(posedge clk) begin : drive_proc
    pending_t head;
    logic     advance;
    logic     raise_start;
    logic     raise_cfg;
    logic     settled;
    logic     quiet_window;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      advance = 1'b0;
      raise_start = 1'b0;
      raise_cfg = 1'b0;
      if (start && !busy) begin
        expected_results.push_back(apply_request(req));
        accepted_total++;
        advance = 1'b1;
      end else if (cfg_valid && cfg_ready) begin
        node_count_reg = cfg_data;
        advance = 1'b1;
      end else if (!start && !cfg_valid) begin
        advance = 1'b1;
      end
      settled = (expected_results.size() == 0) && !done;
      quiet_window = accepted_total >= 700 && accepted_total < 900;
      if (advance) begin
        if (pending_actions.size() != 0) begin
          head = pending_actions[0];
          case (head.kind)
            ACT_REQUEST: begin
              if (quiet_window || $urandom_range(99) >= 19) begin
                raise_start = 1'b1;
                req <= head.req;
                void'(pending_actions.pop_front());
              end
            end
            ACT_CONFIG: begin
              if (settled) begin
                raise_cfg = 1'b1;
                cfg_data <= head.value;
                void'(pending_actions.pop_front());
              end
            end
            default: begin
              if (settled) void'(pending_actions.pop_front());
            end
          endcase
        end
        start <= raise_start;
        cfg_valid <= raise_cfg;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin : watch_proc
    res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, res.neighbour_mask);
      end else begin
        want = expected_results.pop_front();
        check_result(want, res);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= run_limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned midpoint;
    bit          drained;
    for (int i = 0; i < GRAPH_NODES; i++) begin
      graph_rows[i] = '0;
      for (int k = 0; k < GRAPH_NODES; k++) graph_weights[i][k] = '0;
    end
    node_count_reg = NODE_COUNT_RESET;
    plan_nodes = effective_nodes(32'(NODE_COUNT_RESET));

    // Directed requests on the full matrix: empty graph, extreme nodes and
    // weights, self-loop, re-weighting a missing edge, unused codes.
    queue_request(OP_READ, 0, 0, 0);
    queue_request(OP_COUNT, 0, 0, 0);
    queue_request(OP_CONNECT, 0, 0, 0);
    queue_request(OP_ADD, 0, 63, 255);
    queue_request(OP_ADD, 63, 63, 8'hAA);
    queue_request(OP_READ, 63, 0, 0);
    queue_request(OP_READ, 63, 63, 0);
    queue_request(OP_SET_WEIGHT, 0, 63, 8'h5A);
    queue_request(OP_SET_WEIGHT, 1, 2, 255);
    queue_request(OP_READ, 1, 2, 0);
    queue_request(OP_READ, 63, 0, 0);
    queue_request(OP_COUNT, 0, 0, 0);
    queue_request(OP_DELETE, 0, 63, 0);
    queue_request(OP_READ, 0, 63, 0);
    queue_request(OP_SPARE_A, 63, 63, 255);
    queue_request(OP_SPARE_B, 0, 0, 0);
    queue_request(OP_COUNT, 0, 0, 0);
    queue_request(OP_ADD, 5, 9, 1);

    // Shrunk node count: bad indexes, masked rows, node fields ignored by
    // count and connectivity.
    queue_config(3);
    queue_request(OP_READ, 5, 9, 0);
    queue_request(OP_ADD, 0, 3, 7);
    queue_request(OP_ADD, 2, 0, 7);
    queue_request(OP_ADD, 1, 0, 9);
    queue_request(OP_CONNECT, 63, 63, 0);
    queue_request(OP_READ, 0, 1, 0);
    queue_request(OP_COUNT, 63, 63, 0);
    queue_drain();

    // Random phases, each under its own node count, with one drain midway.
    foreach (phase_nodes[k]) begin
      queue_config(phase_nodes[k]);
      target = planned_requests + PHASE_REQUESTS;
      midpoint = planned_requests + PHASE_REQUESTS / 2;
      drained = 1'b0;
      while (planned_requests < target) begin
        if (!drained && planned_requests >= midpoint) begin
          queue_drain();
          drained = 1'b1;
        end
        if (plan_nodes >= 2 && $urandom_range(99) < 4) queue_spanning();
        else queue_random_request();
      end
    end
    run_limit = 3 * cycle_budget + 20000;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last request, then for its result, then a short tail.
    while (pending_actions.size() != 0 || start || cfg_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/amge_pkg.sv
rtl/core/amge_row_mem.sv
rtl/core/amge_wgt_mem.sv
rtl/core/amge_ctrl.sv
rtl/core/adjacency_matrix_graph_engine.sv
tb/adjacency_matrix_graph_engine_test.sv
